[sv/rbsi_pkg.sv]
// Shared types and constants for the ray/box slab intersection block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rbsi_pkg;

  localparam int COORD_W       = 32;  // Q16.16 coordinates and distances
  localparam int DIR_W         = 32;  // Q1.30 direction components
  localparam int RMAG_W        = 63;  // reciprocal magnitude, floor(2^62 / |d|)
  localparam int NUM_AXES      = 3;
  localparam int NUM_PLANES    = 2;   // lower and upper slab plane
  localparam int IDX_W         = 3;
  localparam int IN_DATA_W     = 192;
  localparam int OUT_DATA_W    = 72;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_e;

  // One axis of a ray after the reciprocal pipeline
  typedef struct packed {
    logic [RMAG_W-1:0]  rmag;
    logic               rneg;
    logic [COORD_W-1:0] origin;
  } axis_item_t;

  typedef axis_item_t [NUM_AXES-1:0] ray_item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

  typedef logic [NUM_AXES-1:0][COORD_W-1:0] box_corner_t;

endpackage

[sv/rbsi_recip.sv]
// Pipelined restoring divider forming floor(2^62 / |d|) for one axis, one bit per stage.
// Carries the axis origin alongside. Depends on rbsi_pkg.
`timescale 1ns / 1ps

module rbsi_recip (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rbsi_pkg::DIR_W-1:0]    dir_i,
  input  logic [rbsi_pkg::COORD_W-1:0]  origin_i,
  output rbsi_pkg::axis_item_t          item_o
);
  import rbsi_pkg::*;

  logic [DIR_W-1:0]   dm_q   [RMAG_W+1];
  logic [DIR_W-1:0]   r_q    [RMAG_W+1];
  logic [RMAG_W-1:0]  quo_q  [RMAG_W+1];
  logic               zero_q [RMAG_W+1];
  logic               neg_q  [RMAG_W+1];
  logic [COORD_W-1:0] org_q  [RMAG_W+1];

  logic [DIR_W-1:0] dm_d;

  // Magnitude of the direction; -2^31 maps to 2^31
  assign dm_d = dir_i[DIR_W-1] ? (~dir_i + DIR_W'(1)) : dir_i;

  // Load entry stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dm_q[0]   <= dm_d;
      r_q[0]    <= '0;
      quo_q[0]  <= '0;
      zero_q[0] <= (dir_i == '0);
      neg_q[0]  <= dir_i[DIR_W-1];
      org_q[0]  <= origin_i;
    end
  end

  // One quotient bit per stage, most significant first; only bit 62 of the dividend is set
  for (genvar i = 1; i <= RMAG_W; i++) begin : g_stage
    logic [DIR_W-1:0]  shifted;
    logic              geq;
    logic [DIR_W-1:0]  r_d;
    logic [RMAG_W-1:0] quo_d;

    always_comb begin
      shifted = {r_q[i-1][DIR_W-2:0], (i == 1)};
      geq     = (shifted >= dm_q[i-1]);
      r_d     = geq ? (shifted - dm_q[i-1]) : shifted;
      quo_d   = quo_q[i-1];
      quo_d[RMAG_W-i] = geq;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dm_q[i]   <= dm_q[i-1];
        r_q[i]    <= r_d;
        quo_q[i]  <= quo_d;
        zero_q[i] <= zero_q[i-1];
        neg_q[i]  <= neg_q[i-1];
        org_q[i]  <= org_q[i-1];
      end
    end
  end

  // Zero direction takes the largest positive reciprocal
  assign item_o.rmag   = zero_q[RMAG_W] ? (RMAG_W'(1) << (RMAG_W - 1)) : quo_q[RMAG_W];
  assign item_o.rneg   = zero_q[RMAG_W] ? 1'b0 : neg_q[RMAG_W];
  assign item_o.origin = org_q[RMAG_W];

endmodule

[sv/rbsi_front.sv]
// Front part: accepts rays and runs the three reciprocal pipelines under one stall.
// Depends on rbsi_pkg and rbsi_recip.
`timescale 1ns / 1ps

module rbsi_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rbsi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  rbsi_pkg::queue_flags_t           flags_i,
  output logic                             push_o,
  output rbsi_pkg::ray_item_t              item_o
);
  import rbsi_pkg::*;

  logic [RMAG_W:0] valid_q;
  logic            en;

  // Advance unless a finished ray waits on a full queue
  assign en            = !valid_q[RMAG_W] || !flags_i.full;
  assign s_axis_tready = en;
  assign push_o        = valid_q[RMAG_W] && !flags_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[RMAG_W-1:0], s_axis_tvalid};
    end
  end

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    rbsi_recip u_recip (
      .clk_i    (clk_i),
      .en_i     (en),
      .dir_i    (s_axis_tdata[(NUM_AXES+ax)*COORD_W +: DIR_W]),
      .origin_i (s_axis_tdata[ax*COORD_W +: COORD_W]),
      .item_o   (item_o[ax])
    );
  end

endmodule

[sv/rbsi_queue.sv]
// Short queue between the reciprocal front and the slab back end.
// Depends on rbsi_pkg.
`timescale 1ns / 1ps

module rbsi_queue #(
  parameter int DEPTH = rbsi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  rbsi_pkg::ray_item_t    item_i,
  input  logic                   pop_i,
  output rbsi_pkg::ray_item_t    item_o,
  output rbsi_pkg::queue_flags_t flags_o
);
  import rbsi_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ray_item_t         mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign flags_o.full  = (count_q == CNT_W'(DEPTH));
  assign flags_o.empty = (count_q == '0);
  assign item_o        = mem[rd_ptr_q];

  // Store on push
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

[sv/rbsi_back.sv]
// Back part: plane differences, split products, saturation, slab ordering and result register.
// Depends on rbsi_pkg.
`timescale 1ns / 1ps

module rbsi_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rbsi_pkg::box_corner_t            box_min_i,
  input  rbsi_pkg::box_corner_t            box_max_i,
  input  rbsi_pkg::ray_item_t              item_i,
  input  rbsi_pkg::queue_flags_t           flags_i,
  output logic                             pop_o,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rbsi_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import rbsi_pkg::*;

  localparam int NSTG = 8;
  localparam int HI_W = RMAG_W - COORD_W;
  localparam int MAG_W = 2 * COORD_W;

  logic [NSTG:1] valid_q;
  logic          en;

  logic signed [COORD_W:0]   diff1_q [NUM_AXES][NUM_PLANES];
  logic [RMAG_W-1:0]         rmag1_q [NUM_AXES];
  logic                      rneg1_q [NUM_AXES];
  logic [COORD_W-1:0]        a2_q    [NUM_AXES][NUM_PLANES];
  logic                      dneg2_q [NUM_AXES][NUM_PLANES];
  logic [RMAG_W-1:0]         rmag2_q [NUM_AXES];
  logic                      rneg2_q [NUM_AXES];
  logic [MAG_W-1:0]          plo3_q  [NUM_AXES][NUM_PLANES];
  logic [RMAG_W-1:0]         phi3_q  [NUM_AXES][NUM_PLANES];
  logic                      neg3_q  [NUM_AXES][NUM_PLANES];
  logic [MAG_W-1:0]          mag4_q  [NUM_AXES][NUM_PLANES];
  logic                      neg4_q  [NUM_AXES][NUM_PLANES];
  logic signed [COORD_W-1:0] dist5_q [NUM_AXES][NUM_PLANES];
  logic signed [COORD_W-1:0] smin6_q [NUM_AXES];
  logic signed [COORD_W-1:0] smax6_q [NUM_AXES];
  logic signed [COORD_W-1:0] tnear7_q, tfar7_q;
  logic signed [COORD_W-1:0] tnear8_q, tfar8_q;
  logic                      hit8_q;

  logic signed [COORD_W-1:0] tnear_d, tfar_d;

  // Move the whole pipe together whenever the result register can take a value
  assign en            = !valid_q[NSTG] || m_axis_tready;
  assign pop_o         = en && !flags_i.empty;
  assign m_axis_tvalid = valid_q[NSTG];
  assign m_axis_tdata  = {{(OUT_DATA_W - 2*COORD_W - 1){1'b0}}, hit8_q, tfar8_q, tnear8_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NSTG-1:1], pop_o};
    end
  end

  // Reduce the three slabs
  always_comb begin
    tnear_d = smin6_q[0];
    tfar_d  = smax6_q[0];
    for (int ax = 1; ax < NUM_AXES; ax++) begin
      if (smin6_q[ax] > tnear_d) tnear_d = smin6_q[ax];
      if (smax6_q[ax] < tfar_d)  tfar_d  = smax6_q[ax];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        // Plane minus origin, exact in 33 bits
        diff1_q[ax][0] <= $signed({box_min_i[ax][COORD_W-1], box_min_i[ax]})
                        - $signed({item_i[ax].origin[COORD_W-1], item_i[ax].origin});
        diff1_q[ax][1] <= $signed({box_max_i[ax][COORD_W-1], box_max_i[ax]})
                        - $signed({item_i[ax].origin[COORD_W-1], item_i[ax].origin});
        rmag1_q[ax] <= item_i[ax].rmag;
        rneg1_q[ax] <= item_i[ax].rneg;
        rmag2_q[ax] <= rmag1_q[ax];
        rneg2_q[ax] <= rneg1_q[ax];
        for (int p = 0; p < NUM_PLANES; p++) begin
          // Magnitude of the difference
          dneg2_q[ax][p] <= diff1_q[ax][p][COORD_W];
          a2_q[ax][p]    <= diff1_q[ax][p][COORD_W]
                          ? COORD_W'(-diff1_q[ax][p]) : diff1_q[ax][p][COORD_W-1:0];
          // Split product against low and high reciprocal words
          plo3_q[ax][p] <= a2_q[ax][p] * rmag2_q[ax][COORD_W-1:0];
          phi3_q[ax][p] <= a2_q[ax][p] * rmag2_q[ax][RMAG_W-1:COORD_W];
          neg3_q[ax][p] <= dneg2_q[ax][p] ^ rneg2_q[ax];
          // Combine partial products, truncating 32 fraction bits
          mag4_q[ax][p] <= {{COORD_W{1'b0}}, plo3_q[ax][p][MAG_W-1:COORD_W]}
                         + {{(MAG_W - RMAG_W){1'b0}}, phi3_q[ax][p]};
          neg4_q[ax][p] <= neg3_q[ax][p];
          // Apply sign and saturate
          if (neg4_q[ax][p] && (mag4_q[ax][p] != '0)) begin
            if (mag4_q[ax][p] >= MAG_W'(64'h8000_0000)) begin
              dist5_q[ax][p] <= $signed(32'h8000_0000);
            end else begin
              dist5_q[ax][p] <= $signed(~mag4_q[ax][p][COORD_W-1:0] + COORD_W'(1));
            end
          end else if (mag4_q[ax][p] > MAG_W'(64'h7FFF_FFFF)) begin
            dist5_q[ax][p] <= $signed(32'h7FFF_FFFF);
          end else begin
            dist5_q[ax][p] <= $signed(mag4_q[ax][p][COORD_W-1:0]);
          end
        end
        // Order the two plane distances
        if (dist5_q[ax][0] < dist5_q[ax][1]) begin
          smin6_q[ax] <= dist5_q[ax][0];
          smax6_q[ax] <= dist5_q[ax][1];
        end else begin
          smin6_q[ax] <= dist5_q[ax][1];
          smax6_q[ax] <= dist5_q[ax][0];
        end
      end
      tnear7_q <= tnear_d;
      tfar7_q  <= tfar_d;
      tnear8_q <= tnear7_q;
      tfar8_q  <= tfar7_q;
      hit8_q   <= (tnear7_q < tfar7_q) && (tnear7_q > $signed(COORD_W'(0)));
    end
  end

endmodule

[sv/ray_box_slab_intersect.sv]
// Ray against axis-aligned box, slab method, signed fixed point. One ray enters per clock
// and one result (entry, exit, hit) leaves per clock at full throughput unless the output
// stalls. Its path is one load stage plus the 63-stage reciprocal divider (one quotient
// bit per stage, all three axes side by side), the output queue of the front part, and an
// 8-stage back end holding the plane differences, split 32-bit products, saturation, slab
// ordering and the result register. Write the box corners on the config port while no
// ray is in flight; the block does not enforce it. A zero direction component yields the
// largest positive reciprocal. Depends on rbsi_pkg, rbsi_front, rbsi_queue, rbsi_back.
`timescale 1ns / 1ps

module ray_box_slab_intersect #(
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = rbsi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rbsi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // t_near (32), t_far (32), hit (1), zero fill (7)
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [rbsi_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [rbsi_pkg::IDX_W-1:0]       cfg_idx_i,
  input  logic [rbsi_pkg::COORD_W-1:0]     cfg_data_i
);
  import rbsi_pkg::*;

  box_corner_t    box_min_q, box_max_q;
  logic           push, pop;
  ray_item_t      front_item, queue_item;
  queue_flags_t   flags;

  // Box corner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        box_min_q[ax] <= '0;
        box_max_q[ax] <= COORD_W'(1) << FRAC_BITS;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_X: box_min_q[0] <= cfg_data_i;
        REG_MIN_Y: box_min_q[1] <= cfg_data_i;
        REG_MIN_Z: box_min_q[2] <= cfg_data_i;
        REG_MAX_X: box_max_q[0] <= cfg_data_i;
        REG_MAX_Y: box_max_q[1] <= cfg_data_i;
        REG_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rbsi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .flags_i       (flags),
    .push_o        (push),
    .item_o        (front_item)
  );

  rbsi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (queue_item),
    .flags_o (flags)
  );

  rbsi_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .box_min_i     (box_min_q),
    .box_max_i     (box_max_q),
    .item_i        (queue_item),
    .flags_i       (flags),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

[test/rbsi_checker.sv]
// Checker for the ray/box slab intersection block: predicts each result from
// the accepted rays and the box registers and compares it. Depends on rbsi_pkg.
`timescale 1ns / 1ps

module rbsi_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [rbsi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [rbsi_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [rbsi_pkg::IDX_W-1:0]       cfg_idx_i,
  input  logic [rbsi_pkg::COORD_W-1:0]     cfg_data_i,
  output int                               errors_o,
  output int                               pending_o
);
  import rbsi_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [31:0] t_far;
    logic [31:0] t_near;
  } hit_result_t;

  logic signed [31:0] corner_lo [3];
  logic signed [31:0] corner_hi [3];
  hit_result_t        expected_hits [$];
  int                 err_cnt;

  assign errors_o  = err_cnt;
  assign pending_o = expected_hits.size();

  // diff * recip / 2^32 truncated toward zero, saturated to 32 bits
  function automatic logic signed [31:0] slab_distance(logic signed [33:0] diff,
                                                       logic [62:0] rmag, logic rneg);
    logic [33:0]  amag;
    logic [127:0] prod;
    logic [95:0]  mag;
    amag = diff[33] ? -diff : diff;
    prod = amag * rmag;
    mag  = prod[127:32];
    if (mag == 0) return 0;
    if (diff[33] != rneg) begin
      if (mag >= 96'h8000_0000) return 32'sh8000_0000;
      return -$signed({1'b0, mag[31:0]});
    end
    if (mag > 96'h7fff_ffff) return 32'sh7fff_ffff;
    return mag[31:0];
  endfunction

  function automatic hit_result_t predict_hit(logic [IN_DATA_W-1:0] ray);
    logic signed [31:0] org, dir, lo, hi, smin, smax, tn, tf;
    logic [62:0]        rmag;
    logic [31:0]        dmag;
    hit_result_t        res;
    tn = 0;
    tf = 0;
    for (int ax = 0; ax < 3; ax++) begin
      org = ray[32*ax +: 32];
      dir = ray[32*(ax+3) +: 32];
      if (dir == 0) rmag = 63'h4000_0000_0000_0000;
      else begin
        dmag = dir[31] ? -dir : dir;
        rmag = (64'h4000_0000_0000_0000) / dmag;
      end
      lo = slab_distance(34'(corner_lo[ax]) - 34'(org), rmag, dir[31]);
      hi = slab_distance(34'(corner_hi[ax]) - 34'(org), rmag, dir[31]);
      smin = (lo < hi) ? lo : hi;
      smax = (lo < hi) ? hi : lo;
      if (ax == 0 || smin > tn) tn = smin;
      if (ax == 0 || smax < tf) tf = smax;
    end
    res.t_near = tn;
    res.t_far  = tf;
    res.hit    = (tn < tf) && (tn > 0);
    return res;
  endfunction

  // Track register writes, predict on input transfers, compare output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    hit_result_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        corner_lo[i] = 0;
        corner_hi[i] = 32'sh0001_0000;
      end
      expected_hits.delete();
      err_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[64:0];
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          err_cnt++;
        end else begin
          want = expected_hits.pop_front();
          if (got.t_near !== want.t_near || got.t_far !== want.t_far ||
              got.hit !== want.hit) begin
            $display("%0t: mismatch expected near=%h far=%h hit=%b actual near=%h far=%h hit=%b",
                     $time, want.t_near, want.t_far, want.hit,
                     got.t_near, got.t_far, got.hit);
            err_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_hits.push_back(predict_hit(s_axis_tdata));
      if (cfg_we_i) begin
        if (cfg_idx_i < 3) corner_lo[cfg_idx_i] = cfg_data_i;
        else if (cfg_idx_i < 6) corner_hi[cfg_idx_i - 3] = cfg_data_i;
      end
    end
  end

endmodule

[test/tb.sv]
// Top of the ray/box slab intersection testbench: clock, reset, ray stimulus,
// box register phases and verdict. Depends on rbsi_pkg, rbsi_checker, the block.
`timescale 1ns / 1ps

module tb;
  import rbsi_pkg::*;

  localparam int LATENCY   = 80;
  localparam int MAX_CYCLE = 400000;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 0;
  logic [IDX_W-1:0]      cfg_idx_i = '0;
  logic [COORD_W-1:0]    cfg_data_i = '0;
  int                    errors, pending;
  int                    send_idle_pct = 0, stall_pct = 0;
  int                    cycle_cnt = 0;
  bit                    hold_off = 0;

  ray_box_slab_intersect u_dut (.*);

  rbsi_checker u_chk (.*, .errors_o(errors), .pending_o(pending));

  always #1 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk_i)
    m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(7))
      0: return 0;
      1: return 32'h4000_0000;
      2: return 32'hc000_0000;
      3: return 32'h8000_0000;
      4: return $urandom;
      5: return $urandom_range(3) - 1;
      default: return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endcase
  endfunction

  // Offer one ray and hold it until the transfer
  task automatic send_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {dz, dy, dx, oz, oy, ox};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random(int n);
    repeat (n) send_ray(rand_coord(), rand_coord(), rand_coord(),
                        rand_dir(), rand_dir(), rand_dir());
  endtask

  // Drain every outstanding result, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_box(logic [31:0] lx, ly, lz, hx, hy, hz);
    logic [31:0] vals [6];
    vals = '{lx, ly, lz, hx, hy, hz};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1;
      cfg_idx_i  <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed rays against the reset unit box
    send_ray(32'hffff_0000, 32'h0000_8000, 32'h0000_8000, 32'h4000_0000, 0, 0);
    send_ray(32'h0002_0000, 32'h0000_8000, 32'h0000_8000, 32'hc000_0000, 0, 0);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1);
    send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 1);
    send_ray(32'hffff_8000, 32'hffff_8000, 32'hffff_8000,
             32'h24f3_4e8b, 32'h24f3_4e8b, 32'h24f3_4e8b);
    send_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'hffff_ffff, 32'h7fff_ffff, 0);
    send_ray(32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'h8000_0000, 32'h8000_0000, 0);
    drain();

    // Box settings, extremes and an inverted box among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        1: write_box(32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
                     32'hfffb_0000, 32'hfffb_0000, 32'hfffb_0000);
        2: write_box(32'hfffe_0000, 32'hffff_0000, 32'hfffd_0000,
                     32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
        3: write_box(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 0);
        default: write_box(rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord(), rand_coord());
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      send_random(110);
      if (ph == 2) begin
        // Long receiver hold-off while rays keep coming, enough to fill the pipe
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk_i);
            hold_off = 0;
          end
          begin
            send_random(100);
            s_axis_tvalid <= 0;
          end
        join
      end
      // Pause the sender until the pipe is empty
      drain();
      send_random(30);
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
